>>> src/nearest_scale_crop_to_rgb_defines.svh
// Assertion macros used by the checker file of the scaler.
`ifndef NEAREST_SCALE_CROP_TO_RGB_DEFINES_SVH
`define NEAREST_SCALE_CROP_TO_RGB_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define NSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define NSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/nsc_pkg.sv
// Shared types, constants and helper functions of the nearest-neighbor scaler.
`default_nettype none

package nsc_pkg;

  // Frame store geometry
  localparam int FrameAw = 20;

  // Default size limits of the source frame
  localparam int MaxSourceWidthDef  = 1024;
  localparam int MaxSourceHeightDef = 1024;

  // Configuration port
  localparam int ApbAw = 5;
  localparam int ApbDw = 32;

  // Field widths
  localparam int DimW   = 11;
  localparam int IdxW   = 12;
  localparam int ProdW  = 46;
  localparam int SumW   = 47;
  localparam int CoordW = 30;
  localparam int CoordShift = 17;

  // Color conversion
  localparam int ColorW     = 28;
  localparam int ColorFracW = 16;
  localparam logic signed [8:0] ChromaOffset = 9'sd128;
  localparam logic signed [ColorW-1:0] CoefRCr = 28'sd91991;
  localparam logic signed [ColorW-1:0] CoefGCb = 28'sd22552;
  localparam logic signed [ColorW-1:0] CoefGCr = 28'sd46801;
  localparam logic signed [ColorW-1:0] CoefBCb = 28'sd116130;

  // Register reset values
  localparam logic [DimW-1:0]   SourceWidthRst  = 11'd1024;
  localparam logic [DimW-1:0]   SourceHeightRst = 11'd1024;
  localparam logic signed [31:0] OriginRst = 32'sd0;
  localparam logic signed [31:0] StepRst   = 32'sd65536;

  typedef enum logic [2:0] {
    RegSourceWidth  = 3'd0,
    RegSourceHeight = 3'd1,
    RegOriginX      = 3'd2,
    RegOriginY      = 3'd3,
    RegStepX        = 3'd4,
    RegStepY        = 3'd5
  } reg_addr_e;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cr;
    logic [7:0] cb;
  } pix_t;

  // One item as it travels down the pipeline
  typedef struct packed {
    logic               vld;
    logic               req;
    logic [FrameAw-1:0] idx;
    pix_t               pix;
  } carry_t;

  // Divide by 2^16 toward zero, then saturate to a byte
  function automatic logic [7:0] div_sat(input logic signed [ColorW-1:0] s);
    logic signed [ColorW-1:0] q;
    logic                     fix;
    fix = s[ColorW-1] && (|s[ColorFracW-1:0]);
    q = (s >>> ColorFracW) + $signed({{(ColorW-1){1'b0}}, fix});
    if (q[ColorW-1]) begin
      div_sat = 8'd0;
    end else if (q > ColorW'(255)) begin
      div_sat = 8'd255;
    end else begin
      div_sat = q[7:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/nearest_scale_crop_to_rgb.sv
// Throughput: one transaction (load or request) per cycle; the single frame port
// does one write or one read per cycle, and a stalled result stalls the pipeline.
// Reset: registers take their reset values; the frame memory is not cleared and
// reads of never-loaded pixels give unspecified data. No clearing pass is run.
`default_nettype none

module nearest_scale_crop_to_rgb #(
  parameter int MaxSourceWidth  = nsc_pkg::MaxSourceWidthDef,
  parameter int MaxSourceHeight = nsc_pkg::MaxSourceHeightDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input items
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [19:0] source_index, [27:20] luma_in, [35:28] chroma_red_in,
  // [43:36] chroma_blue_in, [55:44] dest_column, [67:56] dest_row
  input  wire logic [71:0]                 s_axis_tdata,
  // [0] func
  input  wire logic [0:0]                  s_axis_tuser,
  // Result items
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic      [23:0]                 m_axis_tdata,
  // [0] outside
  output logic      [0:0]                  m_axis_tuser,
  // Configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nsc_pkg::ApbAw-1:0]   paddr,
  input  wire logic [nsc_pkg::ApbDw-1:0]   pwdata,
  output logic      [nsc_pkg::ApbDw-1:0]   prdata,
  output logic                             pready
);

  localparam int XW    = $clog2(MaxSourceWidth + 1);
  localparam int YW    = $clog2(MaxSourceHeight + 1);
  localparam int BaseW = XW + YW;
  localparam int AddrSumW = (BaseW > nsc_pkg::FrameAw) ? BaseW : nsc_pkg::FrameAw;

  // Configuration registers
  logic [nsc_pkg::DimW-1:0] width_q, height_q;
  logic signed [31:0]       origin_x_q, origin_y_q, step_x_q, step_y_q;
  nsc_pkg::reg_addr_e       reg_sel;

  // Pipeline
  logic                                advance;
  logic                                in_fire;
  nsc_pkg::carry_t                     pipe_q [1:5];
  nsc_pkg::carry_t                     s1_d;
  logic [nsc_pkg::IdxW-1:0]            s1_col_q, s1_row_q;
  logic signed [nsc_pkg::CoordW-1:0]   xs, ys;
  logic [XW-1:0]                       w_eff;
  logic [YW-1:0]                       h_eff;
  logic                                s5_out_d, s5_out_q;
  logic [XW-1:0]                       s5_xs_q;
  logic [BaseW-1:0]                    s5_base_d, s5_base_q;
  logic [nsc_pkg::FrameAw-1:0]         pix_addr;
  nsc_pkg::carry_t                     s6_d, s6_q;
  logic                                s6_out_q;
  logic                                ram_we, ram_re;
  nsc_pkg::pix_t                       ram_rdata;
  logic                                s7_vld_q, s7_out_q;
  logic [7:0]                          s7_luma;
  logic signed [8:0]                   s7_rd, s7_bd;
  logic signed [nsc_pkg::ColorW-1:0]   rd_ext, bd_ext;
  logic                                s8_vld_q, s8_out_q;
  logic [7:0]                          s8_luma_q;
  logic signed [nsc_pkg::ColorW-1:0]   s8_r_cr_q, s8_g_cb_q, s8_g_cr_q, s8_b_cb_q;
  logic signed [nsc_pkg::ColorW-1:0]   y_term, red_sum, green_sum, blue_sum;
  logic                                m_vld_q, m_out_q;
  logic [23:0]                         m_rgb_d, m_rgb_q;

  // Write configuration registers
  assign reg_sel = nsc_pkg::reg_addr_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= nsc_pkg::SourceWidthRst;
      height_q   <= nsc_pkg::SourceHeightRst;
      origin_x_q <= nsc_pkg::OriginRst;
      origin_y_q <= nsc_pkg::OriginRst;
      step_x_q   <= nsc_pkg::StepRst;
      step_y_q   <= nsc_pkg::StepRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        nsc_pkg::RegSourceWidth:  width_q    <= pwdata[nsc_pkg::DimW-1:0];
        nsc_pkg::RegSourceHeight: height_q   <= pwdata[nsc_pkg::DimW-1:0];
        nsc_pkg::RegOriginX:      origin_x_q <= $signed(pwdata);
        nsc_pkg::RegOriginY:      origin_y_q <= $signed(pwdata);
        nsc_pkg::RegStepX:        step_x_q   <= $signed(pwdata);
        nsc_pkg::RegStepY:        step_y_q   <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_sel)
      nsc_pkg::RegSourceWidth:  prdata = nsc_pkg::ApbDw'(width_q);
      nsc_pkg::RegSourceHeight: prdata = nsc_pkg::ApbDw'(height_q);
      nsc_pkg::RegOriginX:      prdata = origin_x_q;
      nsc_pkg::RegOriginY:      prdata = origin_y_q;
      nsc_pkg::RegStepX:        prdata = step_x_q;
      nsc_pkg::RegStepY:        prdata = step_y_q;
      default:                  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Whole pipeline moves unless a result waits at the output
  assign advance       = !m_vld_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_fire       = s_axis_tvalid && advance;

  // Capture an accepted transaction
  assign s1_d.vld      = in_fire;
  assign s1_d.req      = s_axis_tuser[0];
  assign s1_d.idx      = s_axis_tdata[19:0];
  assign s1_d.pix.luma = s_axis_tdata[27:20];
  assign s1_d.pix.cr   = s_axis_tdata[35:28];
  assign s1_d.pix.cb   = s_axis_tdata[43:36];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= 5; k++) begin
        pipe_q[k] <= '0;
      end
    end else if (advance) begin
      pipe_q[1] <= s1_d;
      for (int k = 2; k <= 5; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_col_q <= s_axis_tdata[55:44];
      s1_row_q <= s_axis_tdata[67:56];
    end
  end

  // Map destination coordinates to source coordinates
  nsc_coord_map u_map_x (
    .clk_i    (clk_i),
    .en_i     (advance),
    .index_i  (s1_col_q),
    .origin_i (origin_x_q),
    .step_i   (step_x_q),
    .coord_o  (xs)
  );

  nsc_coord_map u_map_y (
    .clk_i    (clk_i),
    .en_i     (advance),
    .index_i  (s1_row_q),
    .origin_i (origin_y_q),
    .step_i   (step_y_q),
    .coord_o  (ys)
  );

  // Limit frame size to the supported maximum
  always_comb begin
    if (32'(width_q) > 32'(MaxSourceWidth)) begin
      w_eff = XW'(MaxSourceWidth);
    end else begin
      w_eff = XW'(width_q);
    end
    if (32'(height_q) > 32'(MaxSourceHeight)) begin
      h_eff = YW'(MaxSourceHeight);
    end else begin
      h_eff = YW'(height_q);
    end
  end

  // Bounds test and row base; negative coordinates compare as huge
  assign s5_out_d  = ($unsigned(xs) >= nsc_pkg::CoordW'(w_eff)) ||
                     ($unsigned(ys) >= nsc_pkg::CoordW'(h_eff));
  assign s5_base_d = BaseW'(ys[YW-1:0]) * BaseW'(w_eff);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s5_out_q  <= s5_out_d;
      s5_xs_q   <= xs[XW-1:0];
      s5_base_q <= s5_base_d;
    end
  end

  // Form the frame address; loads keep their own address
  assign pix_addr = nsc_pkg::FrameAw'(AddrSumW'(s5_xs_q) + AddrSumW'(s5_base_q));

  always_comb begin
    s6_d = pipe_q[5];
    if (pipe_q[5].req) begin
      s6_d.idx = pix_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_q <= '0;
    end else if (advance) begin
      s6_q <= s6_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s6_out_q <= s5_out_q;
    end
  end

  // Frame access: loads and requests reach the port in order, one per cycle while
  // the pipeline advances, so a read always sees every earlier load
  assign ram_we = advance && s6_q.vld && !s6_q.req;
  assign ram_re = advance && s6_q.vld && s6_q.req;

  nsc_ram #(
    .Width ($bits(nsc_pkg::pix_t)),
    .Depth (2 ** nsc_pkg::FrameAw)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (s6_q.idx),
    .wdata_i (s6_q.pix),
    .rdata_o (ram_rdata)
  );

  // Track requests waiting on read data; loads end here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
    end else if (advance) begin
      s7_vld_q <= s6_q.vld && s6_q.req;
      s8_vld_q <= s7_vld_q;
      m_vld_q  <= s8_vld_q;
    end
  end

  // Substitute black for pixels outside the frame
  always_comb begin
    if (s7_out_q) begin
      s7_luma = 8'd0;
      s7_rd   = 9'sd0;
      s7_bd   = 9'sd0;
    end else begin
      s7_luma = ram_rdata.luma;
      s7_rd   = $signed({1'b0, ram_rdata.cr}) - nsc_pkg::ChromaOffset;
      s7_bd   = $signed({1'b0, ram_rdata.cb}) - nsc_pkg::ChromaOffset;
    end
  end

  assign rd_ext = nsc_pkg::ColorW'(s7_rd);
  assign bd_ext = nsc_pkg::ColorW'(s7_bd);

  // Multiply chroma by the matrix coefficients
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s7_out_q  <= s6_out_q;
      s8_out_q  <= s7_out_q;
      s8_luma_q <= s7_luma;
      s8_r_cr_q <= rd_ext * nsc_pkg::CoefRCr;
      s8_g_cb_q <= bd_ext * nsc_pkg::CoefGCb;
      s8_g_cr_q <= rd_ext * nsc_pkg::CoefGCr;
      s8_b_cb_q <= bd_ext * nsc_pkg::CoefBCb;
    end
  end

  // Sum, scale down and saturate each channel
  assign y_term    = $signed(nsc_pkg::ColorW'({s8_luma_q, 16'h0000}));
  assign red_sum   = y_term + s8_r_cr_q;
  assign green_sum = y_term - s8_g_cb_q - s8_g_cr_q;
  assign blue_sum  = y_term + s8_b_cb_q;
  assign m_rgb_d   = {nsc_pkg::div_sat(blue_sum), nsc_pkg::div_sat(green_sum),
                      nsc_pkg::div_sat(red_sum)};

  // Hold the result until the transaction completes
  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_rgb_q <= m_rgb_d;
      m_out_q <= s8_out_q;
    end
  end

  assign m_axis_tvalid   = m_vld_q;
  assign m_axis_tdata    = m_rgb_q;
  assign m_axis_tuser[0] = m_out_q;

endmodule

`default_nettype wire

>>> src/nsc_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module nsc_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write or read one entry per cycle; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/nsc_coord_map.sv
// Three-stage Q16.16 coordinate mapper: origin + (2*index+1)*step/2, toward zero.
`default_nettype none

module nsc_coord_map (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic        [nsc_pkg::IdxW-1:0]   index_i,
  input  wire logic signed [31:0]                origin_i,
  input  wire logic signed [31:0]                step_i,
  output logic      signed [nsc_pkg::CoordW-1:0] coord_o
);

  logic signed [nsc_pkg::IdxW+1:0]   odd;
  logic signed [nsc_pkg::ProdW-1:0]  prod_d, prod_q;
  logic signed [nsc_pkg::SumW-1:0]   origin2;
  logic signed [nsc_pkg::SumW-1:0]   sum_d, sum_q;
  logic signed [nsc_pkg::CoordW-1:0] quot;
  logic                              fix;
  logic signed [nsc_pkg::CoordW-1:0] coord_d;

  // Odd multiple of the half step
  assign odd    = $signed({1'b0, index_i, 1'b1});
  assign prod_d = odd * step_i;

  // Add twice the origin, all in units of 2^-17
  assign origin2 = $signed({{(nsc_pkg::SumW-33){origin_i[31]}}, origin_i, 1'b0});
  assign sum_d   = nsc_pkg::SumW'(prod_q) + origin2;

  // Shift down and round negative fractions toward zero
  assign quot    = nsc_pkg::CoordW'(sum_q >>> nsc_pkg::CoordShift);
  assign fix     = sum_q[nsc_pkg::SumW-1] && (|sum_q[nsc_pkg::CoordShift-1:0]);
  assign coord_d = quot + $signed({{(nsc_pkg::CoordW-1){1'b0}}, fix});

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      sum_q   <= sum_d;
      coord_o <= coord_d;
    end
  end

endmodule

`default_nettype wire

>>> src/nsc_checker.sv
// Port-level checker for the scaler, bound to the top level.
`default_nettype none

`include "nearest_scale_crop_to_rgb_defines.svh"

module nsc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic [71:0]               s_axis_tdata,
  input wire logic [0:0]                s_axis_tuser,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [23:0]               m_axis_tdata,
  input wire logic [0:0]                m_axis_tuser,
  input wire logic                      psel,
  input wire logic                      penable,
  input wire logic                      pwrite,
  input wire logic [nsc_pkg::ApbAw-1:0] paddr,
  input wire logic [nsc_pkg::ApbDw-1:0] pwdata,
  input wire logic [nsc_pkg::ApbDw-1:0] prdata,
  input wire logic                      pready
);

  // Configuration port never waits
  `NSC_ASSERT_NOW(a_pready_high, clk_i, rst_ni, 1'b1, pready, "pready dropped")

  // A stalled result holds its value
  `NSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Input is taken whenever no result is pending
  `NSC_ASSERT_NOW(a_in_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled while output empty")

  // Pixels outside the frame come out black
  `NSC_ASSERT_NOW(a_outside_black, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata == 24'h000000, "outside pixel is not black")

endmodule

bind nearest_scale_crop_to_rgb nsc_checker u_nsc_checker (.*);

`default_nettype wire

>>> sim/tb_nearest_scale_crop_to_rgb.sv
// Self-checking testbench for the nearest-neighbor crop/scale block with YCbCr to RGB output.

module tb_nearest_scale_crop_to_rgb;
  import nsc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 12;
  localparam int SettleCycles  = 20;

  typedef enum logic {
    FuncLoad    = 1'b0,
    FuncRequest = 1'b1
  } func_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       outside;
  } rgb_pixel_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata;
  logic [0:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [23:0]        m_axis_tdata;
  logic [0:0]         m_axis_tuser;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ApbAw-1:0]   paddr;
  logic [ApbDw-1:0]   pwdata;
  logic [ApbDw-1:0]   prdata;
  logic               pready;

  // Predictor state: loaded source pixels and the current register settings
  pix_t               source_pixels[int unsigned];
  rgb_pixel_t         rgb_expected_q[$];
  rgb_pixel_t         rgb_head;
  logic [DimW-1:0]    width_q;
  logic [DimW-1:0]    height_q;
  logic signed [31:0] origin_x_q;
  logic signed [31:0] origin_y_q;
  logic signed [31:0] step_x_q;
  logic signed [31:0] step_y_q;

  int mismatches  = 0;
  int items_sent  = 0;
  int quiet_count = 0;
  bit bursty      = 1'b1;

  nearest_scale_crop_to_rgb DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Map a destination index to a source coordinate at pixel centers, truncating toward zero
  function automatic longint nearest_coord(logic signed [31:0] origin, logic signed [31:0] step,
                                           logic [IdxW-1:0] dest);
    longint twice;
    twice = 2 * longint'(origin) + (2 * longint'(dest) + 1) * longint'(step);
    return twice / 131072;
  endfunction

  // Return 1 when the request lands inside the frame; addr gets the raster address
  function automatic bit source_inside(logic [IdxW-1:0] col, logic [IdxW-1:0] row,
                                       output logic [FrameAw-1:0] addr);
    longint w;
    longint h;
    longint xs;
    longint ys;
    w  = (width_q > MaxSourceWidthDef) ? MaxSourceWidthDef : longint'(width_q);
    h  = (height_q > MaxSourceHeightDef) ? MaxSourceHeightDef : longint'(height_q);
    xs = nearest_coord(origin_x_q, step_x_q, col);
    ys = nearest_coord(origin_y_q, step_y_q, row);
    addr = FrameAw'(xs + ys * w);
    return xs >= 0 && xs < w && ys >= 0 && ys < h;
  endfunction

  function automatic logic [7:0] clamp_channel(longint sum);
    longint q;
    q = sum / 65536;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // Fetch the mapped pixel (black when outside) and convert with the full-range matrix
  function automatic rgb_pixel_t convert_request(logic [IdxW-1:0] col, logic [IdxW-1:0] row);
    rgb_pixel_t         px;
    logic [FrameAw-1:0] addr;
    longint             luma;
    longint             cr_d;
    longint             cb_d;
    bit                 in_frame;
    in_frame = source_inside(col, row, addr);
    luma = 0;
    cr_d = 0;
    cb_d = 0;
    if (in_frame) begin
      luma = longint'(source_pixels[addr].luma);
      cr_d = longint'(source_pixels[addr].cr) - 128;
      cb_d = longint'(source_pixels[addr].cb) - 128;
    end
    px.red     = clamp_channel(65536 * luma + 91991 * cr_d);
    px.green   = clamp_channel(65536 * luma - 22552 * cb_d - 46801 * cr_d);
    px.blue    = clamp_channel(65536 * luma + 116130 * cb_d);
    px.outside = !in_frame;
    return px;
  endfunction

  function automatic pix_t random_pixel();
    return pix_t'(24'($urandom));
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Drive one input transaction, wait for acceptance, then update the predictor
  task automatic send_item(func_e func, logic [FrameAw-1:0] index, pix_t pix,
                           logic [IdxW-1:0] col, logic [IdxW-1:0] row);
    if (bursty && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'd0, row, col, pix.cb, pix.cr, pix.luma, index};
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FuncLoad) begin
      source_pixels[index] = pix;
    end else begin
      rgb_expected_q.push_back(convert_request(col, row));
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_load(logic [FrameAw-1:0] index, pix_t pix);
    send_item(FuncLoad, index, pix, IdxW'($urandom), IdxW'($urandom));
  endtask

  // Load the mapped pixel first if it was never written, then request it
  task automatic send_request(logic [IdxW-1:0] col, logic [IdxW-1:0] row);
    logic [FrameAw-1:0] addr;
    if (source_inside(col, row, addr) && !source_pixels.exists(addr)) begin
      send_load(addr, random_pixel());
    end
    send_item(FuncRequest, FrameAw'($urandom), random_pixel(), col, row);
  endtask

  // Hold off input until every result is back and in-flight loads have retired
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (rgb_expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_reg(reg_addr_e sel, logic [31:0] value);
    logic [31:0] mask;
    mask = (sel == RegSourceWidth || sel == RegSourceHeight) ? 32'h7FF : 32'hFFFF_FFFF;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      RegSourceWidth:  width_q    = value[DimW-1:0];
      RegSourceHeight: height_q   = value[DimW-1:0];
      RegOriginX:      origin_x_q = value;
      RegOriginY:      origin_y_q = value;
      RegStepX:        step_x_q   = value;
      RegStepY:        step_y_q   = value;
      default: ;
    endcase
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %s expected %h actual %h", $time, sel.name(), value & mask,
               prdata & mask);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_config(logic [DimW-1:0] w, logic [DimW-1:0] h,
                              logic signed [31:0] ox, logic signed [31:0] oy,
                              logic signed [31:0] sx, logic signed [31:0] sy);
    drain_pipeline();
    write_reg(RegSourceWidth, 32'(w));
    write_reg(RegSourceHeight, 32'(h));
    write_reg(RegOriginX, ox);
    write_reg(RegOriginY, oy);
    write_reg(RegStepX, sx);
    write_reg(RegStepY, sy);
  endtask

  // Extreme components at the frame corners under the reset geometry
  task automatic test_reset_geometry();
    send_load(20'd0, pix_t'{luma: 8'hFF, cr: 8'hFF, cb: 8'hFF});
    send_load(20'd1, pix_t'{luma: 8'h00, cr: 8'h00, cb: 8'h00});
    send_load(20'd2, pix_t'{luma: 8'h00, cr: 8'hFF, cb: 8'h00});
    send_load(20'd1024, pix_t'{luma: 8'hFF, cr: 8'h00, cb: 8'h00});
    send_load(20'hFFFFF, pix_t'{luma: 8'h80, cr: 8'h80, cb: 8'h80});
    send_request(12'd0, 12'd0);
    send_request(12'd1, 12'd0);
    send_request(12'd2, 12'd0);
    send_request(12'd0, 12'd1);
    send_request(12'd1023, 12'd1023);
    send_request(12'd4095, 12'd0);
    send_request(12'd0, 12'd4095);
  endtask

  // Empty frame, oversized frame saturated to the maximum, and a zero step
  task automatic test_frame_size_limits();
    apply_config(11'd0, 11'd5, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536);
    send_request(12'd0, 12'd0);
    apply_config(11'd2047, 11'd2047, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536);
    send_request(12'd1023, 12'd1023);
    send_request(12'd1024, 12'd0);
    send_request(12'd5, 12'd3);
    apply_config(11'd1, 11'd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_request(12'd4095, 12'd4095);
    send_request(12'd0, 12'd0);
  endtask

  // Register extremes, negative steps and truncation toward zero near the edge
  task automatic test_coordinate_limits();
    apply_config(11'd2047, 11'd2047, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(12'd0, 12'd0);
    send_request(12'd4095, 12'd4095);
    apply_config(11'd16, 11'd16, 32'sd0, -32'sd49152, -32'sd65536, 32'sd65536);
    send_request(12'd0, 12'd0);
    send_request(12'd1, 12'd0);
    send_request(12'd0, 12'd1);
  endtask

  function automatic logic [DimW-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DimW'($urandom_range(MaxSourceWidthDef + 1, 2047));
      2:       return DimW'(MaxSourceWidthDef);
      default: return DimW'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic signed [31:0] random_step();
    logic signed [31:0] s;
    if ($urandom_range(0, 9) == 0) return $urandom;
    s = $urandom_range(8192, 262144);
    if ($urandom_range(0, 3) == 0) s = -s;
    return s;
  endfunction

  // Place the origin around the frame, a pixel before its near edge at most
  function automatic logic signed [31:0] random_origin(logic [DimW-1:0] dim);
    logic signed [31:0] o;
    int                 span;
    if ($urandom_range(0, 9) == 0) return $urandom;
    span = (dim > MaxSourceWidthDef) ? MaxSourceWidthDef : int'(dim);
    o = $urandom_range(0, span * 65536);
    return o - 32'sd65536;
  endfunction

  // Random geometry phases with mostly in-frame requests; no idling at the tail
  task automatic test_random_scaling(int items);
    int               target;
    logic [DimW-1:0]  w;
    logic [DimW-1:0]  h;
    logic [IdxW-1:0]  col;
    logic [IdxW-1:0]  row;
    target = items_sent + items;
    while (items_sent < target) begin
      w = random_dim();
      h = random_dim();
      apply_config(w, h, random_origin(w), random_origin(h), random_step(), random_step());
      bursty = (items_sent < target - items / 6) && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(60, 160)) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            send_load(FrameAw'($urandom), random_pixel());
          end else begin
            send_load(FrameAw'($urandom_range(0, 4095)), random_pixel());
          end
        end else begin
          col = ($urandom_range(0, 7) == 0) ? IdxW'($urandom) : IdxW'($urandom_range(0, 63));
          row = ($urandom_range(0, 7) == 0) ? IdxW'($urandom) : IdxW'($urandom_range(0, 63));
          send_request(col, row);
        end
      end
    end
  endtask

  // Stall the result side in random bursts
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && bursty && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest predicted pixel
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rgb_expected_q.size() == 0) begin
        $display("%0t: expected no result, actual rgb %h outside %b", $time, m_axis_tdata,
                 m_axis_tuser);
        mismatches++;
      end else begin
        rgb_head = rgb_expected_q.pop_front();
        check_field("red", rgb_head.red, m_axis_tdata[7:0]);
        check_field("green", rgb_head.green, m_axis_tdata[15:8]);
        check_field("blue", rgb_head.blue, m_axis_tdata[23:16]);
        check_field("outside", 8'(rgb_head.outside), 8'(m_axis_tuser[0]));
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || !rst_ni) begin
      quiet_count <= 0;
    end else if (quiet_count >= WatchdogLimit) begin
      $display("nearest_scale_crop_to_rgb: mismatch");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    width_q       = SourceWidthRst;
    height_q      = SourceHeightRst;
    origin_x_q    = OriginRst;
    origin_y_q    = OriginRst;
    step_x_q      = StepRst;
    step_y_q      = StepRst;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_geometry();
    test_frame_size_limits();
    test_coordinate_limits();
    test_random_scaling(1250);

    drain_pipeline();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("nearest_scale_crop_to_rgb: match");
    end else begin
      $display("nearest_scale_crop_to_rgb: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/nsc_pkg.sv
src/nsc_ram.sv
src/nsc_coord_map.sv
src/nearest_scale_crop_to_rgb.sv
src/nsc_checker.sv
sim/tb_nearest_scale_crop_to_rgb.sv
